>>> rtl/ple_pkg.sv
package ple_pkg;

  localparam int LEN_W = 8;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  localparam logic [1:0] SEL_POS   = 2'd0;
  localparam logic [1:0] SEL_FRONT = 2'd1;
  localparam logic [1:0] SEL_BACK  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    cell_op_t         op;
    logic [LEN_W-1:0] tgt;
    logic [LEN_W-1:0] last_idx;
  } cell_ctrl_t;

endpackage

>>> rtl/ple_cell.sv
module ple_cell import ple_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] front_data,
  output logic [DATA_WIDTH-1:0] data_q
);

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_INS: begin
        if (MY_IDX > ctrl.tgt) begin
          data_nxt = left_data;
        end else if (MY_IDX == ctrl.tgt) begin
          data_nxt = ins_data;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= ctrl.tgt) begin
          data_nxt = right_data;
        end
      end
      OP_ROT: begin
        if (MY_IDX == ctrl.last_idx) begin
          data_nxt = front_data;
        end else if (MY_IDX < ctrl.last_idx) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

>>> rtl/positional_list_engine.sv
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | in_req_type in_end_select in_position in_item_value
// result  | out_valid | out_stall | out_status out_entry_count out_entry_value out_last_result
//
// insert, delete and other one-result requests are applied in a row of list cells
// a dump of n entries: a start step, then one entry per cycle while results are not stalled,
// rotating through the cell row and read through the single front-cell port
// synchronous active-low reset empties the list; cell contents are not cleared
// a stalled result holds the result register, and the next item waits behind it
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_end_select,
  input  logic [5:0]  in_position,
  input  logic [31:0] in_item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_count,
  output logic [31:0] out_entry_value,
  output logic        out_last_result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] ins_data;
  logic [63:0]           in_ext;
  logic [63:0]           front_ext;
  cell_ctrl_t            ctrl;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  len_r, len_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [5:0]     out_count_r, out_count_nxt;
  logic [31:0]    out_value_r, out_value_nxt;
  logic           out_last_r, out_last_nxt;

  logic             out_free;
  logic [LEN_W-1:0] len_ext;
  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] p_ins;
  logic [LEN_W-1:0] p_del;
  logic             ins_bad;
  logic             del_bad;
  logic             is_full;
  logic             dump_last;

  assign in_ext    = 64'(in_item_value);
  assign ins_data  = in_ext[DATA_WIDTH-1:0];
  assign front_ext = 64'(cell_q[0]);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_left
        assign left_d = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign right_d = '0;
      end else begin : g_right
        assign right_d = cell_q[gi+1];
      end
      ple_cell #(
        .IDX        (gi),
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .ins_data   (ins_data),
        .left_data  (left_d),
        .right_data (right_d),
        .front_data (cell_q[0]),
        .data_q     (cell_q[gi])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;

  assign len_ext = LEN_W'(len_r);
  assign pos_ext = LEN_W'(in_position);
  assign is_full = len_ext >= LEN_W'(CAPACITY);

  assign p_ins = (in_end_select == SEL_FRONT) ? LEN_W'(1) :
                 (in_end_select == SEL_BACK)  ? len_ext + LEN_W'(1) : pos_ext;
  assign ins_bad = (in_end_select != SEL_POS && in_end_select != SEL_FRONT &&
                    in_end_select != SEL_BACK) ||
                   (p_ins == '0) || (p_ins > len_ext + LEN_W'(1));

  assign p_del = (in_end_select == SEL_FRONT) ? LEN_W'(1) :
                 (in_end_select == SEL_BACK)  ? len_ext : pos_ext;
  assign del_bad = (p_del == '0) || (p_del > len_ext);

  assign dump_last = (CW'(k_r + 1'b1) == len_r);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    ctrl.op        = OP_HOLD;
    ctrl.tgt       = '0;
    ctrl.last_idx  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          case (in_req_type)
            REQ_INSERT: begin
              if (ins_bad) begin
                out_status_nxt = ST_BADPOS;
              end else if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.op  = OP_INS;
                ctrl.tgt = p_ins - LEN_W'(1);
                len_nxt  = CW'(len_r + 1'b1);
              end
            end
            REQ_DELETE: begin
              if (in_end_select != SEL_POS && in_end_select != SEL_FRONT &&
                  in_end_select != SEL_BACK) begin
                out_status_nxt = ST_BADPOS;
              end else if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (del_bad) begin
                out_status_nxt = ST_BADPOS;
              end else begin
                ctrl.op  = OP_DEL;
                ctrl.tgt = p_del - LEN_W'(1);
                len_nxt  = CW'(len_r - 1'b1);
              end
            end
            REQ_DUMP: begin
              if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                k_nxt         = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: out_status_nxt = ST_OK;
          endcase
          out_count_nxt = 6'(len_nxt);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_count_nxt  = 6'(len_r);
          out_value_nxt  = front_ext[31:0];
          out_last_nxt   = dump_last;
          ctrl.op        = OP_ROT;
          ctrl.last_idx  = len_ext - LEN_W'(1);
          if (dump_last) begin
            k_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = CW'(k_r + 1'b1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_entry_value = out_value_r;
  assign out_last_result = out_last_r;

endmodule

>>> tb/positional_list_engine_tb.sv
module positional_list_engine_tb;
  import ple_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] SEL_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  count;
    logic [31:0] value;
    logic        is_last;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [1:0]  in_end_select;
  logic [5:0]  in_position;
  logic [31:0] in_item_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [5:0]  out_entry_count;
  logic [31:0] out_entry_value;
  logic        out_last_result;

  logic [31:0] list_vals[$];
  reply_t      replies_due[$];

  int errors = 0;
  int reqs_sent = 0;
  int dumps_sent = 0;
  int results_seen = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  bit send_eager = 1'b0;
  bit sink_eager = 1'b0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  positional_list_engine #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(32)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_end_select(in_end_select),
    .in_position(in_position),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_count(out_entry_count),
    .out_entry_value(out_entry_value),
    .out_last_result(out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("timeout at %0t, %0d results still pending", $time, replies_due.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic void queue_reply(logic [1:0] st, logic [31:0] v, logic is_last);
    reply_t r;
    r.status  = st;
    r.count   = 6'(list_vals.size());
    r.value   = v;
    r.is_last = is_last;
    replies_due.push_back(r);
    status_tally[st]++;
  endfunction

  function automatic void apply_request(logic [1:0] req, logic [1:0] sel, logic [5:0] pos,
                                        logic [31:0] val);
    int n;
    int target;
    n = list_vals.size();
    target = int'(pos);
    case (req)
      REQ_INSERT: begin
        if (sel == SEL_FRONT) target = 1;
        else if (sel == SEL_BACK) target = n + 1;
        if (sel == SEL_UNUSED || target < 1 || target > n + 1) begin
          queue_reply(ST_BADPOS, '0, 1'b1);
        end else if (n >= CAPACITY) begin
          queue_reply(ST_FULL, '0, 1'b1);
        end else begin
          list_vals.insert(target - 1, val);
          queue_reply(ST_OK, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (sel == SEL_UNUSED) begin
          queue_reply(ST_BADPOS, '0, 1'b1);
        end else if (n == 0) begin
          queue_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          if (sel == SEL_FRONT) target = 1;
          else if (sel == SEL_BACK) target = n;
          if (target < 1 || target > n) begin
            queue_reply(ST_BADPOS, '0, 1'b1);
          end else begin
            list_vals.delete(target - 1);
            queue_reply(ST_OK, '0, 1'b1);
          end
        end
      end
      REQ_DUMP: begin
        if (n == 0) begin
          queue_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) queue_reply(ST_OK, list_vals[i], i == n - 1);
        end
      end
      default: queue_reply(ST_OK, '0, 1'b1);
    endcase
  endfunction

  task automatic send_req(input logic [1:0] req, input logic [1:0] sel, input logic [5:0] pos,
                          input logic [31:0] val);
    int gap;
    gap = send_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_end_select <= sel;
    in_position   <= pos;
    in_item_value <= val;
    do @(posedge clk); while (in_stall);
    apply_request(req, sel, pos, val);
    reqs_sent++;
    if (req == REQ_DUMP) dumps_sent++;
  endtask

  task automatic send_random(input int ins_weight);
    int n;
    int r;
    logic [1:0] req;
    logic [1:0] sel;
    logic [5:0] pos;
    n = list_vals.size();
    r = $urandom_range(0, 99);
    if (r < ins_weight) req = REQ_INSERT;
    else if (r < 87) req = REQ_DELETE;
    else if (r < 97) req = REQ_DUMP;
    else req = REQ_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 30) sel = SEL_FRONT;
    else if (r < 55) sel = SEL_BACK;
    else if (r < 94) sel = SEL_POS;
    else sel = SEL_UNUSED;
    pos = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) < 8) begin
      if (req == REQ_INSERT) pos = 6'($urandom_range(1, n + 1));
      else if (req == REQ_DELETE && n > 0) pos = 6'($urandom_range(1, n));
    end
    send_req(req, sel, pos, pick_value());
  endtask

  // random stall pattern on the result side, with an optional long hold
  initial begin : result_sink
    int span;
    logic level;
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        level       = 1'b1;
        span        = HOLD_CYCLES;
      end else begin
        hold_active = 1'b0;
        if (sink_eager) begin
          level = 1'b0;
          span  = 1;
        end else begin
          level = ($urandom_range(0, 2) == 0);
          span  = level ? pick_gap() + 1 : $urandom_range(1, 12);
        end
      end
      repeat (span) begin
        out_stall <= level;
        @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: status %0d count %0d value %h last %b", $time,
                 out_status, out_entry_count, out_entry_value, out_last_result);
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_entry_count !== want.count) begin
          errors++;
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   out_entry_count);
        end
        if (out_entry_value !== want.value) begin
          errors++;
          $display("%0t: entry_value expected %h actual %h", $time, want.value,
                   out_entry_value);
        end
        if (out_last_result !== want.is_last) begin
          errors++;
          $display("%0t: last_result expected %b actual %b", $time, want.is_last,
                   out_last_result);
        end
      end
    end
  end

  task automatic test_basic_requests();
    send_req(REQ_DUMP, SEL_POS, 6'd0, 32'h0);
    send_req(REQ_DELETE, SEL_POS, 6'd0, 32'h0);
    send_req(REQ_DELETE, SEL_FRONT, 6'd1, 32'h0);
    send_req(REQ_DELETE, SEL_BACK, 6'd1, 32'h0);
    send_req(REQ_DELETE, SEL_POS, 6'd63, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, SEL_POS, 6'd0, 32'h1234_5678);
    send_req(REQ_INSERT, SEL_POS, 6'd2, 32'h1234_5678);
    send_req(REQ_INSERT, SEL_UNUSED, 6'd1, 32'h1234_5678);
    send_req(REQ_INSERT, SEL_FRONT, 6'd0, 32'h0);
    send_req(REQ_INSERT, SEL_BACK, 6'd63, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, SEL_POS, 6'd2, 32'hA5A5_A5A5);
    send_req(REQ_INSERT, SEL_POS, 6'd4, 32'h5A5A_5A5A);
    send_req(REQ_INSERT, SEL_POS, 6'd63, 32'h0F0F_0F0F);
    send_req(REQ_DUMP, SEL_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send_req(REQ_DELETE, SEL_UNUSED, 6'd1, 32'h0);
    send_req(REQ_DELETE, SEL_POS, 6'd5, 32'h0);
    send_req(REQ_DELETE, SEL_POS, 6'd0, 32'h0);
    send_req(REQ_DELETE, SEL_POS, 6'd2, 32'hFFFF_FFFF);
    send_req(REQ_DELETE, SEL_BACK, 6'd0, 32'h0);
    send_req(REQ_UNUSED, SEL_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send_req(REQ_DUMP, SEL_BACK, 6'd2, 32'h0);
    // two entries left, delete must remove only one
    send_req(REQ_DELETE, SEL_FRONT, 6'd0, 32'h0);
    send_req(REQ_DUMP, SEL_FRONT, 6'd0, 32'h0);
    send_req(REQ_DELETE, SEL_POS, 6'd1, 32'h0);
    send_req(REQ_DUMP, SEL_POS, 6'd1, 32'h0);
  endtask

  task automatic test_full_list();
    logic [1:0] sel;
    while (list_vals.size() < CAPACITY) begin
      sel = 2'($urandom_range(0, 2));
      send_req(REQ_INSERT, sel, 6'($urandom_range(1, list_vals.size() + 1)), pick_value());
    end
    send_req(REQ_INSERT, SEL_FRONT, 6'd0, 32'hDEAD_BEEF);
    send_req(REQ_INSERT, SEL_BACK, 6'd0, 32'hDEAD_BEEF);
    send_req(REQ_INSERT, SEL_POS, 6'd33, 32'hDEAD_BEEF);
    send_req(REQ_INSERT, SEL_POS, 6'd1, 32'hDEAD_BEEF);
    send_req(REQ_INSERT, SEL_POS, 6'd34, 32'hDEAD_BEEF);
    send_req(REQ_INSERT, SEL_POS, 6'd0, 32'hDEAD_BEEF);
    send_req(REQ_DELETE, SEL_POS, 6'd33, 32'h0);
    send_req(REQ_DUMP, SEL_POS, 6'd0, 32'h0);
    while (list_vals.size() > 0) begin
      sel = 2'($urandom_range(0, 2));
      send_req(REQ_DELETE, sel, 6'($urandom_range(1, list_vals.size())), pick_value());
    end
    send_req(REQ_DELETE, SEL_POS, 6'd1, 32'h0);
    send_req(REQ_DUMP, SEL_POS, 6'd0, 32'h0);
  endtask

  task automatic test_back_pressure();
    in_valid <= 1'b0;
    hold_req = 1'b1;
    wait (hold_active);
    @(posedge clk);
    send_eager = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 10 == 9) send_req(REQ_DUMP, SEL_POS, 6'd0, pick_value());
      else send_req(REQ_INSERT, SEL_BACK, 6'd0, pick_value());
    end
    send_eager = 1'b0;
  endtask

  task automatic test_random_mix();
    int ins_weight;
    bit calm;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 2))
        0: ins_weight = 20;
        1: ins_weight = 50;
        default: ins_weight = 75;
      endcase
      calm = (phase == 3) || ($urandom_range(0, 3) == 0);
      send_eager = calm;
      sink_eager = calm;
      repeat (18) send_random(ins_weight);
    end
    send_eager = 1'b0;
    sink_eager = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_INSERT;
    in_end_select <= SEL_POS;
    in_position   <= '0;
    in_item_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_requests();
    test_full_list();
    test_back_pressure();
    test_random_mix();

    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests (%0d dumps) sent, %0d results checked", reqs_sent, dumps_sent,
             results_seen);
    $display("status mix: ok %0d, bad position %0d, empty %0d, full %0d", status_tally[0],
             status_tally[1], status_tally[2], status_tally[3]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
